@@ src/qss_pkg.sv @@
`default_nettype none

package qss_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int SCREEN_BITS_DEF = 12;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // register index codes (byte address = 4 * index)
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BORDER_HEIGHT = 2'd2;

    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd600;
    localparam logic [10:0] BORDER_HEIGHT_RST = 11'd15;

    typedef struct packed {
        logic [12:0] pix_width;
        logic [12:0] line_count;
        logic [10:0] margin_lines;
    } cfg_t;

    // control that rides alongside the edge datapath
    typedef struct packed {
        logic valid;
        logic band;
    } side_t;

endpackage

`default_nettype wire

@@ src/qss_apb_regs.sv @@
`default_nettype none

module qss_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qss_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [qss_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [qss_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    output qss_pkg::cfg_t                          cfg
);

    qss_pkg::cfg_t cfg_reg;
    qss_pkg::cfg_t cfg_next;
    logic [1:0]    idx;
    logic          wr;

    assign idx = paddr[3:2];
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                qss_pkg::REG_SCREEN_WIDTH:  cfg_next.pix_width    = pwdata[12:0];
                qss_pkg::REG_SCREEN_HEIGHT: cfg_next.line_count   = pwdata[12:0];
                qss_pkg::REG_BORDER_HEIGHT: cfg_next.margin_lines = pwdata[10:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pix_width    <= qss_pkg::SCREEN_WIDTH_RST;
            cfg_reg.line_count   <= qss_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.margin_lines <= qss_pkg::BORDER_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            qss_pkg::REG_SCREEN_WIDTH:  prdata = {19'd0, cfg_reg.pix_width};
            qss_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_reg.line_count};
            qss_pkg::REG_BORDER_HEIGHT: prdata = {21'd0, cfg_reg.margin_lines};
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

@@ src/qss_div_step.sv @@
`default_nettype none

// one restoring division step: shift in a dividend bit, subtract if it fits
module qss_div_step #(
    parameter int DW  = 17,
    parameter int XBW = 16
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [2*DW-1:0]   acc_in,
    input  wire logic [DW-1:0]     dmag_in,
    input  wire logic              neg_in,
    input  wire logic              hit_in,
    input  wire logic [XBW-1:0]    xa_in,
    output logic      [2*DW-1:0]   acc_out,
    output logic      [DW-1:0]     dmag_out,
    output logic                   neg_out,
    output logic                   hit_out,
    output logic      [XBW-1:0]    xa_out
);

    localparam int PW = 2 * DW;

    logic [PW:0]       shifted;
    logic [DW:0]       upper;
    logic [DW:0]       diff;
    logic              fits;
    logic [PW-1:0]     acc_next;
    logic [PW-1:0]     acc_reg;
    logic [DW-1:0]     dmag_reg;
    logic              neg_reg;
    logic              hit_reg;
    logic [XBW-1:0]    xa_reg;

    always_comb
    begin
        shifted = {acc_in, 1'b0};
        upper   = shifted[PW:DW];
        diff    = upper - {1'b0, dmag_in};
        fits    = (upper >= {1'b0, dmag_in});
        if (fits)
            acc_next = {diff[DW-1:0], shifted[DW-1:1], 1'b1};
        else
            acc_next = shifted[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= acc_next;
            dmag_reg <= dmag_in;
            neg_reg  <= neg_in;
            hit_reg  <= hit_in;
            xa_reg   <= xa_in;
        end
    end

    assign acc_out  = acc_reg;
    assign dmag_out = dmag_reg;
    assign neg_out  = neg_reg;
    assign hit_out  = hit_reg;
    assign xa_out   = xa_reg;

endmodule

`default_nettype wire

@@ src/qss_edge_div.sv @@
`default_nettype none

// crossing x of one edge: magnitude multiply, bit-per-stage divide, sign and offset
module qss_edge_div #(
    parameter int COORD_BITS = qss_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic                         hit,
    input  wire logic signed [COORD_BITS:0]   t,
    input  wire logic signed [COORD_BITS:0]   m,
    input  wire logic signed [COORD_BITS:0]   d,
    input  wire logic signed [COORD_BITS-1:0] xa,
    output logic                              x_hit,
    output logic signed [COORD_BITS+1:0]      x
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = COORD_BITS + 2;

    logic [DW-1:0] tmag;
    logic [DW-1:0] mmag;
    logic [DW-1:0] dmag;

    logic [PW-1:0]         prod_reg;
    logic [DW-1:0]         dmag_reg;
    logic                  neg_reg;
    logic                  hit_reg;
    logic [COORD_BITS-1:0] xa_reg;

    logic [PW-1:0]         acc_w  [0:DW];
    logic [DW-1:0]         dmag_w [0:DW];
    logic                  neg_w  [0:DW];
    logic                  hit_w  [0:DW];
    logic [COORD_BITS-1:0] xa_w   [0:DW];

    logic signed [XW-1:0] q_signed;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] x_reg;
    logic                 x_hit_reg;

    assign tmag = t[DW-1] ? (~t + 1'b1) : t;
    assign mmag = m[DW-1] ? (~m + 1'b1) : m;
    assign dmag = d[DW-1] ? (~d + 1'b1) : d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= tmag * mmag;
            dmag_reg <= dmag;
            neg_reg  <= t[DW-1] ^ m[DW-1] ^ d[DW-1];
            hit_reg  <= hit;
            xa_reg   <= xa;
        end
    end

    assign acc_w[0]  = prod_reg;
    assign dmag_w[0] = dmag_reg;
    assign neg_w[0]  = neg_reg;
    assign hit_w[0]  = hit_reg;
    assign xa_w[0]   = xa_reg;

    for (genvar i = 0; i < DW; i++)
    begin : g_step
        qss_div_step #(
            .DW  (DW),
            .XBW (COORD_BITS)
        ) u_step (
            .clk      (clk),
            .en       (en),
            .acc_in   (acc_w[i]),
            .dmag_in  (dmag_w[i]),
            .neg_in   (neg_w[i]),
            .hit_in   (hit_w[i]),
            .xa_in    (xa_w[i]),
            .acc_out  (acc_w[i+1]),
            .dmag_out (dmag_w[i+1]),
            .neg_out  (neg_w[i+1]),
            .hit_out  (hit_w[i+1]),
            .xa_out   (xa_w[i+1])
        );
    end

    always_comb
    begin
        if (neg_w[DW])
            q_signed = -$signed({1'b0, acc_w[DW][DW-1:0]});
        else
            q_signed = $signed({1'b0, acc_w[DW][DW-1:0]});
        x_next = q_signed + XW'($signed(xa_w[DW]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            x_hit_reg <= hit_w[DW];
        end
    end

    assign x     = x_reg;
    assign x_hit = x_hit_reg;

endmodule

`default_nettype wire

@@ src/quad_scanline_span_unit.sv @@
`default_nettype none

// span generator for one scanline through a quad
// throughput: one beat per cycle while the result channel is not stalled; the depth comes
//   from the per-edge divider, one quotient bit per stage, COORD_BITS + 1 stages
// reset: registers return to 800 / 600 / 15, the pipeline empties, no result pending
module quad_scanline_span_unit #(
    parameter int COORD_BITS  = qss_pkg::COORD_BITS_DEF,
    parameter int SCREEN_BITS = qss_pkg::SCREEN_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qss_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [qss_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [qss_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    // request channel
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [COORD_BITS-1:0]             vert0_x,
    input  wire logic [COORD_BITS-1:0]             vert0_y,
    input  wire logic [COORD_BITS-1:0]             vert1_x,
    input  wire logic [COORD_BITS-1:0]             vert1_y,
    input  wire logic [COORD_BITS-1:0]             vert2_x,
    input  wire logic [COORD_BITS-1:0]             vert2_y,
    input  wire logic [COORD_BITS-1:0]             vert3_x,
    input  wire logic [COORD_BITS-1:0]             vert3_y,
    input  wire logic [SCREEN_BITS-1:0]            scan_y,
    // result channel
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic                                   span_valid,
    output logic      [SCREEN_BITS-1:0]            span_start,
    output logic      [SCREEN_BITS-1:0]            span_end
);

    // widths
    localparam int DW    = COORD_BITS + 1;             // vertex differences
    localparam int XW    = COORD_BITS + 2;             // crossing x
    localparam int YB0   = (COORD_BITS > 14) ? COORD_BITS : 14;
    localparam int CW    = ((YB0 > SCREEN_BITS) ? YB0 : SCREEN_BITS) + 2;  // y compares
    localparam int MW    = ((XW > SCREEN_BITS + 2) ? XW : SCREEN_BITS + 2) + 1;
    localparam int EW    = (SCREEN_BITS + 1 > 14) ? SCREEN_BITS + 1 : 14;  // width clamp
    localparam int DEPTH = DW + 3;                     // stage 0, multiply, divide, sum

    qss_pkg::cfg_t cfg;

    qss_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the whole pipeline moves together; it holds only when a finished beat is blocked
    logic en;
    logic rsp_valid_reg;

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    // stage 0: band test and edge operands
    logic signed [COORD_BITS-1:0] vx [0:3];
    logic signed [COORD_BITS-1:0] vy [0:3];
    logic signed [CW-1:0]         vyc [0:3];
    logic signed [CW-1:0]         yy;
    logic signed [CW-1:0]         ymin;
    logic signed [CW-1:0]         ymax;
    logic signed [CW-1:0]         border_c;
    logic signed [CW-1:0]         bot_lim;
    logic                         band;

    assign vx[0] = vert0_x;
    assign vx[1] = vert1_x;
    assign vx[2] = vert2_x;
    assign vx[3] = vert3_x;
    assign vy[0] = vert0_y;
    assign vy[1] = vert1_y;
    assign vy[2] = vert2_y;
    assign vy[3] = vert3_y;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            vyc[k] = CW'(vy[k]);
        yy       = $signed(CW'(scan_y));
        border_c = $signed(CW'(cfg.margin_lines));
        bot_lim  = $signed(CW'(cfg.line_count)) - CW'(1) - border_c;
        ymin     = vyc[0];
        ymax     = vyc[0];
        for (int k = 1; k < 4; k++)
        begin
            if (vyc[k] < ymin)
                ymin = vyc[k];
            if (vyc[k] > ymax)
                ymax = vyc[k];
        end
        // top line inclusive, bottom line exclusive
        band = (yy >= ymin) && (yy >= border_c) && (yy < ymax) && (yy < bot_lim);
    end

    logic                         hit_reg [0:3];
    logic signed [DW-1:0]         t_reg   [0:3];
    logic signed [DW-1:0]         m_reg   [0:3];
    logic signed [DW-1:0]         d_reg   [0:3];
    logic signed [COORD_BITS-1:0] xa_reg  [0:3];

    logic                         x_hit [0:3];
    logic signed [XW-1:0]         x     [0:3];

    // edges in the order v3->v0, v0->v1, v1->v2, v2->v3
    for (genvar k = 0; k < 4; k++)
    begin : g_edge
        localparam int A = (k + 3) % 4;

        logic                 hit_next;
        logic signed [CW-1:0] t_full;

        always_comb
        begin
            hit_next = (vyc[A] != vyc[k])
                && ((vyc[A] >= yy) || (vyc[k] >= yy))
                && ((vyc[A] <= yy) || (vyc[k] <= yy));
            t_full   = yy - vyc[A];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hit_reg[k] <= hit_next;
                // t only matters on a hit, and then it lies within the edge's y span
                t_reg[k]   <= t_full[DW-1:0];
                m_reg[k]   <= DW'(vx[k]) - DW'(vx[A]);
                d_reg[k]   <= DW'(vy[k]) - DW'(vy[A]);
                xa_reg[k]  <= vx[A];
            end
        end

        qss_edge_div #(
            .COORD_BITS (COORD_BITS)
        ) u_edge (
            .clk   (clk),
            .en    (en),
            .hit   (hit_reg[k]),
            .t     (t_reg[k]),
            .m     (m_reg[k]),
            .d     (d_reg[k]),
            .xa    (xa_reg[k]),
            .x_hit (x_hit[k]),
            .x     (x[k])
        );
    end

    // valid and band flag walk beside the edge units
    qss_pkg::side_t side_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0].valid <= req_valid;
            side_reg[0].band  <= band;
            for (int i = 1; i < DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // final stage: min / max over crossing edges, clamp to the screen
    logic signed [MW-1:0]          xm_lo [0:3];
    logic signed [MW-1:0]          xm_hi [0:3];
    logic signed [MW-1:0]          lo01, lo23, lo;
    logic signed [MW-1:0]          hi01, hi23, hi;
    logic signed [MW-1:0]          lo_c, hi_c;
    logic signed [MW-1:0]          right;
    logic        [EW-1:0]          w_eff;
    logic                          any_hit;
    logic                          span_valid_next;
    logic        [SCREEN_BITS-1:0] span_start_next;
    logic        [SCREEN_BITS-1:0] span_end_next;

    localparam logic [EW-1:0] W_MAX = EW'(1 << SCREEN_BITS);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            xm_lo[k] = x_hit[k] ? MW'(x[k]) : $signed({1'b0, {(MW-1){1'b1}}});
            xm_hi[k] = x_hit[k] ? MW'(x[k]) : $signed({1'b1, {(MW-1){1'b0}}});
        end
        lo01 = (xm_lo[0] < xm_lo[1]) ? xm_lo[0] : xm_lo[1];
        lo23 = (xm_lo[2] < xm_lo[3]) ? xm_lo[2] : xm_lo[3];
        lo   = (lo01 < lo23) ? lo01 : lo23;
        hi01 = (xm_hi[0] > xm_hi[1]) ? xm_hi[0] : xm_hi[1];
        hi23 = (xm_hi[2] > xm_hi[3]) ? xm_hi[2] : xm_hi[3];
        hi   = (hi01 > hi23) ? hi01 : hi23;

        // wide screens are cut to the field width
        w_eff = (EW'(cfg.pix_width) > W_MAX) ? W_MAX : EW'(cfg.pix_width);
        right = $signed(MW'(w_eff)) - MW'(1);

        lo_c    = (lo < 0) ? '0 : lo;
        hi_c    = (hi > right) ? right : hi;
        any_hit = x_hit[0] || x_hit[1] || x_hit[2] || x_hit[3];

        span_valid_next = side_reg[DEPTH-1].band && any_hit && (lo_c <= hi_c);
        span_start_next = span_valid_next ? lo_c[SCREEN_BITS-1:0] : '0;
        span_end_next   = span_valid_next ? hi_c[SCREEN_BITS-1:0] : '0;
    end

    logic                   span_valid_reg;
    logic [SCREEN_BITS-1:0] span_start_reg;
    logic [SCREEN_BITS-1:0] span_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
            rsp_valid_reg <= side_reg[DEPTH-1].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_valid_reg <= span_valid_next;
            span_start_reg <= span_start_next;
            span_end_reg   <= span_end_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign span_valid = span_valid_reg;
    assign span_start = span_start_reg;
    assign span_end   = span_end_reg;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CB = qss_pkg::COORD_BITS_DEF;
    localparam int SB = qss_pkg::SCREEN_BITS_DEF;

    typedef struct {
        logic [CB-1:0] vx[4];
        logic [CB-1:0] vy[4];
        logic [SB-1:0] line;
    } quad_req_t;

    typedef struct {
        logic          ok;
        logic [SB-1:0] x0;
        logic [SB-1:0] x1;
    } span_t;

    // span predictor with its own copy of the register file
    class span_board;
        logic [12:0] width_q;
        logic [12:0] height_q;
        logic [10:0] border_q;
        span_t       pending[$];
        int          errors;

        function new();
            width_q  = qss_pkg::SCREEN_WIDTH_RST;
            height_q = qss_pkg::SCREEN_HEIGHT_RST;
            border_q = qss_pkg::BORDER_HEIGHT_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                qss_pkg::REG_SCREEN_WIDTH:  width_q  = v[12:0];
                qss_pkg::REG_SCREEN_HEIGHT: height_q = v[12:0];
                qss_pkg::REG_BORDER_HEIGHT: border_q = v[10:0];
                default: ;
            endcase
        endfunction

        function span_t predict(quad_req_t r);
            longint xs[4], ys[4];
            longint yl, top, bot, w, lo, hi, num, den, q, x;
            int a;
            span_t s;
            yl = longint'(r.line);
            for (int k = 0; k < 4; k++)
            begin
                xs[k] = longint'($signed(r.vx[k]));
                ys[k] = longint'($signed(r.vy[k]));
            end
            top = ys[0];
            bot = ys[0];
            for (int k = 1; k < 4; k++)
            begin
                if (ys[k] < top) top = ys[k];
                if (ys[k] > bot) bot = ys[k];
            end
            if (top < longint'(border_q)) top = longint'(border_q);
            if (bot > longint'(height_q) - 1 - longint'(border_q))
                bot = longint'(height_q) - 1 - longint'(border_q);
            w = longint'(width_q);
            if (w > (64'sd1 <<< SB)) w = 64'sd1 <<< SB;
            lo = w;
            hi = -1;
            // edges v3->v0, v0->v1, v1->v2, v2->v3
            for (int k = 0; k < 4; k++)
            begin
                a = (k + 3) & 3;
                if (ys[a] == ys[k]) continue;
                if ((ys[a] >= yl || ys[k] >= yl) && (ys[a] <= yl || ys[k] <= yl))
                begin
                    num = (yl - ys[a]) * (xs[k] - xs[a]);
                    den = ys[k] - ys[a];
                    q = num / den;  // truncates toward zero, operands well within 64 bits
                    x = q + xs[a];
                    if (x < lo) lo = x;
                    if (x > hi) hi = x;
                end
            end
            if (lo < 0) lo = 0;
            if (hi > w - 1) hi = w - 1;
            s.ok = 0; s.x0 = '0; s.x1 = '0;
            if (yl >= top && yl < bot && lo <= hi)
            begin
                s.ok = 1;
                s.x0 = lo[SB-1:0];
                s.x1 = hi[SB-1:0];
            end
            return s;
        endfunction

        function void note_request(quad_req_t r);
            pending.push_back(predict(r));
        endfunction

        function void check_span(logic ok, logic [SB-1:0] x0, logic [SB-1:0] x1);
            span_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected span beat: valid=%0d start=%0d end=%0d", ok, x0, x1);
                return;
            end
            e = pending.pop_front();
            if (e.ok !== ok || e.x0 !== x0 || e.x1 !== x1)
            begin
                errors++;
                if (errors <= 10)
                    $display("span mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                             e.ok, e.x0, e.x1, ok, x0, x1);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [qss_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [qss_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [qss_pkg::CFG_DATA_BITS-1:0] prdata;
    logic pready;
    logic req_valid = 0;
    logic req_stall;
    logic [CB-1:0] vert0_x = '0, vert0_y = '0, vert1_x = '0, vert1_y = '0;
    logic [CB-1:0] vert2_x = '0, vert2_y = '0, vert3_x = '0, vert3_y = '0;
    logic [SB-1:0] scan_y = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    logic span_valid;
    logic [SB-1:0] span_start, span_end;

    span_board board = new();
    bit sending_done = 0;

    always #6 clk = ~clk;

    quad_scanline_span_unit DUT (.*);

    // mostly short gaps, now and then a long one, sometimes none for a stretch
    function automatic int gap_len(int burst);
        if (burst != 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // result side: random stall, check each accepted beat
    initial
    begin
        int n;
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                board.check_span(span_valid, span_start, span_end);
            burst = ($urandom_range(0, 99) < 30);
            if (n > 0)
            begin
                n--;
                rsp_stall <= 1;
            end
            else
            begin
                n = gap_len(burst);
                rsp_stall <= (n > 0);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= qss_pkg::CFG_ADDR_BITS'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic set_screen(int w, int h, int b);
        reg_write(qss_pkg::REG_SCREEN_WIDTH, w);
        reg_write(qss_pkg::REG_SCREEN_HEIGHT, h);
        reg_write(qss_pkg::REG_BORDER_HEIGHT, b);
    endtask

    // one request beat, held until the block takes it; valid stays up between
    // back to back beats and drops only ahead of a gap
    task automatic send_quad(quad_req_t r, int gap);
        if (gap > 0)
        begin
            req_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        vert0_x <= r.vx[0]; vert0_y <= r.vy[0];
        vert1_x <= r.vx[1]; vert1_y <= r.vy[1];
        vert2_x <= r.vx[2]; vert2_y <= r.vy[2];
        vert3_x <= r.vx[3]; vert3_y <= r.vy[3];
        scan_y <= r.line;
        req_valid <= 1;
        do @(posedge clk); while (req_stall);
        board.note_request(r);
    endtask

    // random quad; mostly near the screen so the line crosses it
    function automatic quad_req_t rand_quad(int h);
        quad_req_t r;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++)
        begin
            if (mode < 6)
            begin
                r.vx[k] = CB'($signed($urandom_range(0, 1400)) - 300);
                r.vy[k] = CB'($signed($urandom_range(0, h + 100)) - 50);
            end
            else if (mode < 8)
            begin
                r.vx[k] = CB'($urandom);
                r.vy[k] = CB'($signed($urandom_range(0, 5000)) - 500);
            end
            else
            begin
                r.vx[k] = CB'($urandom);
                r.vy[k] = CB'($urandom);
            end
        end
        // flat edge now and then
        if ($urandom_range(0, 7) == 0) r.vy[1] = r.vy[0];
        r.line = ($urandom_range(0, 9) < 8) ? SB'($urandom_range(0, h + 20)) : SB'($urandom);
        return r;
    endfunction

    function automatic quad_req_t mk(int x0, int y0, int x1, int y1,
                                     int x2, int y2, int x3, int y3, int ln);
        quad_req_t r;
        r.vx[0] = CB'(x0); r.vy[0] = CB'(y0);
        r.vx[1] = CB'(x1); r.vy[1] = CB'(y1);
        r.vx[2] = CB'(x2); r.vy[2] = CB'(y2);
        r.vx[3] = CB'(x3); r.vy[3] = CB'(y3);
        r.line = SB'(ln);
        return r;
    endfunction

    task automatic drain();
        req_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_phase(int count, int h);
        int burst;
        for (int i = 0; i < count; i++)
        begin
            burst = ((i / 64) % 3 == 0);
            send_quad(rand_quad(h), gap_len(burst));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed beats at reset settings
        send_quad(mk(100, 100, 300, 100, 300, 300, 100, 300, 200), 0);  // axis square
        send_quad(mk(100, 100, 300, 100, 300, 300, 100, 300, 10), 0);   // in top border
        send_quad(mk(100, 100, 300, 100, 300, 300, 100, 300, 300), 0);  // bottom excluded
        send_quad(mk(100, 100, 300, 100, 300, 300, 100, 300, 100), 0);  // top inclusive
        send_quad(mk(-500, 0, 2000, 0, 2000, 599, -500, 599, 300), 0);   // both clamps
        send_quad(mk(900, 50, 1000, 50, 1000, 400, 900, 400, 100), 0);  // right of screen
        send_quad(mk(-90, 50, -10, 50, -10, 400, -90, 400, 100), 0);    // left of zero
        send_quad(mk(400, 50, 400, 50, 400, 50, 400, 50, 50), 0);       // all flat
        send_quad(mk(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 4095), 0);
        send_quad(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 0), 0);
        send_quad(mk(0, 20, 799, 580, 0, 580, 799, 20, 333), 0);        // bow tie
        send_quad(mk(7, 20, 10, 500, 3, 500, 1, 20, 257), 0);           // thin sliver
        send_quad(mk(-32768, 20, 32767, 21, 5, 32767, 1, -32768, 21), 0);
        send_quad(mk(10, 20, 30, 500, 50, 20, 40, 500, 0), 0);
        random_phase(300, 600);
        drain();

        // wide screen, no border, tall
        set_screen(4096, 4096, 0);
        send_quad(mk(-100, 0, 5000, 0, 5000, 4095, -100, 4095, 4094), 0);
        send_quad(mk(-100, 0, 5000, 0, 5000, 4095, -100, 4095, 0), 0);
        random_phase(400, 4096);
        drain();

        set_screen(8191, 8191, 2047);   // field maxima, wide screen beyond 2^12
        random_phase(200, 4096);
        drain();

        set_screen(0, 600, 15);         // zero width: every span empty
        random_phase(100, 600);
        drain();

        set_screen(1, 1, 0);            // single pixel, single line
        random_phase(100, 8);
        drain();

        set_screen(640, 100, 60);       // inverted band
        random_phase(100, 100);
        drain();

        set_screen(1920, 1080, 5);
        random_phase(450, 1080);
        req_valid <= 0;

        sending_done = 1;
    end

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("FAILURE");
        $finish;
    end

endmodule
